// File: hw/rtl/stt_pkg.sv
// Shared types and constants of the source tracking table.
`default_nettype none

package stt_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 32;
  localparam int unsigned ADDR_W          = 16;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned SLOT_W          = 5;
  localparam int unsigned COUNT_W         = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QUEUE_PTR_W     = 1;
  localparam int unsigned QUEUE_CNT_W     = 2;

  typedef struct packed {
    logic [ADDR_W-1:0] sender_addr;
    logic [TIME_W-1:0] now_ms;
    logic              has_data;
    logic [BYTE_W-1:0] data_value;
    logic              has_battery;
    logic [BYTE_W-1:0] battery_value;
  } report_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] last_seen;
    logic [TIME_W-1:0] last_report;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] battery;
  } entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic               evicted;
    logic [BYTE_W-1:0]  data_out;
    logic [BYTE_W-1:0]  battery_out;
    logic [TIME_W-1:0]  elapsed_ms;
    logic [COUNT_W-1:0] report_count;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/source_tracking_table.sv
// Reports are handled one at a time: each is taken from the queue, then a one-entry-a-cycle
// scan of the single-port table memory is followed by a re-read and write of the entry,
// and the next report is taken from the queue only after that write.
// A two-entry input queue and the result register let both sides stall on their own.
// Reset clears the entry valid bits, queue and report count at once; invalid
// entries read as free with zero times and readings, so no clearing pass is needed.
`default_nettype none

module source_tracking_table #(
  parameter int unsigned TableSlots = stt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [stt_pkg::ADDR_W-1:0]   sender_addr_i,
  input  wire logic [stt_pkg::TIME_W-1:0]   now_ms_i,
  input  wire logic                         has_data_i,
  input  wire logic [stt_pkg::BYTE_W-1:0]   data_value_i,
  input  wire logic                         has_battery_i,
  input  wire logic [stt_pkg::BYTE_W-1:0]   battery_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [stt_pkg::SLOT_W-1:0]        slot_o,
  output logic                              hit_o,
  output logic                              evicted_o,
  output logic [stt_pkg::BYTE_W-1:0]        data_out_o,
  output logic [stt_pkg::BYTE_W-1:0]        battery_out_o,
  output logic [stt_pkg::TIME_W-1:0]        elapsed_ms_o,
  output logic [stt_pkg::COUNT_W-1:0]       report_count_o
);

  stt_pkg::report_t in_rep, q_rep;
  stt_pkg::result_t res;
  logic             q_valid, q_pop;

  assign in_rep.sender_addr   = sender_addr_i;
  assign in_rep.now_ms        = now_ms_i;
  assign in_rep.has_data      = has_data_i;
  assign in_rep.data_value    = data_value_i;
  assign in_rep.has_battery   = has_battery_i;
  assign in_rep.battery_value = battery_value_i;

  stt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_rep),
    .out_valid_o (q_valid),
    .out_pop_i   (q_pop),
    .out_o       (q_rep)
  );

  stt_engine #(
    .TableSlots (TableSlots)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_i       (q_rep),
    .req_pop_o   (q_pop),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign slot_o         = res.slot;
  assign hit_o          = res.hit;
  assign evicted_o      = res.evicted;
  assign data_out_o     = res.data_out;
  assign battery_out_o  = res.battery_out;
  assign elapsed_ms_o   = res.elapsed_ms;
  assign report_count_o = res.report_count;

endmodule

`default_nettype wire

// File: hw/rtl/stt_queue.sv
// Front end: accepts reports and holds them in a short queue for the engine.
`default_nettype none

module stt_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire stt_pkg::report_t in_i,
  output logic                  out_valid_o,
  input  wire logic             out_pop_i,
  output stt_pkg::report_t      out_o
);

  stt_pkg::report_t                buf_q [stt_pkg::QUEUE_DEPTH];
  logic [stt_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [stt_pkg::QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [stt_pkg::QUEUE_CNT_W-1:0] count_q, count_d;
  logic                            push, pop;

  assign in_stall_o  = (count_q == stt_pkg::QUEUE_CNT_W'(stt_pkg::QUEUE_DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_o       = buf_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = out_pop_i && out_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/stt_engine.sv
// Back end: table memory, lookup scan, entry update and result register.
`default_nettype none

module stt_engine #(
  parameter int unsigned TableSlots = stt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  input  wire stt_pkg::report_t req_i,
  output logic                  req_pop_o,
  output logic                  res_valid_o,
  input  wire logic             res_stall_i,
  output stt_pkg::result_t      res_o
);

  localparam int unsigned IdxW = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableSlots - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_LAST = 3'd2;
  localparam logic [2:0] ST_PICK = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  // table memory and per-entry valid bits (invalid entry reads as zero)
  stt_pkg::entry_t  mem_q [TableSlots];
  logic [TableSlots-1:0] vld_q;
  stt_pkg::entry_t  rd_data_q;
  logic             rd_vld_q;
  logic             rd_en, wr_en;
  logic [IdxW-1:0]  rd_addr;
  stt_pkg::entry_t  wr_data;
  stt_pkg::entry_t  ent, base;

  logic [2:0]       state_q, state_d;
  logic [IdxW-1:0]  iss_q, iss_d;
  logic             cmp_v_q, cmp_v_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic             found_q, found_d;
  logic [IdxW-1:0]  match_q, match_d;
  logic             free_q, free_d;
  logic [IdxW-1:0]  free_idx_q, free_idx_d;
  logic [stt_pkg::TIME_W-1:0] min_ls_q, min_ls_d;
  logic [IdxW-1:0]  min_idx_q, min_idx_d;
  logic [IdxW-1:0]  sel_q, sel_d, pick_idx;
  logic             hit_q, hit_d;
  logic             ev_q, ev_d;
  stt_pkg::report_t req_q, req_d;
  logic [stt_pkg::COUNT_W-1:0] total_q, total_d;
  logic             out_valid_q, out_valid_d;
  stt_pkg::result_t out_q, out_d;

  assign ent         = rd_vld_q ? rd_data_q : '0;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    priority if (found_q) begin
      pick_idx = match_q;
    end else if (free_q) begin
      pick_idx = free_idx_q;
    end else begin
      pick_idx = min_idx_q;
    end
  end

  // an evicted entry starts from cleared readings and times
  assign base = ev_q ? '0 : ent;

  always_comb begin
    wr_data.addr        = req_q.sender_addr;
    wr_data.last_seen   = req_q.now_ms;
    wr_data.last_report = req_q.now_ms;
    wr_data.data        = req_q.has_data ? req_q.data_value : base.data;
    wr_data.battery     = req_q.has_battery ? req_q.battery_value : base.battery;
  end

  always_comb begin
    state_d     = state_q;
    iss_d       = iss_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = iss_q;
    found_d     = found_q;
    match_d     = match_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    min_ls_d    = min_ls_q;
    min_idx_d   = min_idx_q;
    sel_d       = sel_q;
    hit_d       = hit_q;
    ev_d        = ev_q;
    req_d       = req_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = iss_q;
    wr_en       = 1'b0;
    req_pop_o   = 1'b0;

    if (out_valid_q && !res_stall_i) begin
      out_valid_d = 1'b0;
    end

    // compare stage: one entry per cycle, in the cycle after its read
    if (cmp_v_q) begin
      if (!found_q && ent.addr == req_q.sender_addr) begin
        found_d = 1'b1;
        match_d = cmp_idx_q;
      end
      if (!free_q && ent.addr == '0) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
      if (cmp_idx_q == '0 || ent.last_seen < min_ls_q) begin
        min_ls_d  = ent.last_seen;
        min_idx_d = cmp_idx_q;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          req_d     = req_i;
          iss_d     = '0;
          found_d   = 1'b0;
          free_d    = 1'b0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en     = 1'b1;
        rd_addr   = iss_q;
        cmp_v_d   = 1'b1;
        cmp_idx_d = iss_q;
        if (iss_q == LastIdx) begin
          state_d = ST_LAST;
        end else begin
          iss_d = iss_q + 1'b1;
        end
      end
      ST_LAST: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        rd_en   = 1'b1;
        rd_addr = pick_idx;
        sel_d   = pick_idx;
        hit_d   = found_q;
        ev_d    = !found_q && !free_q;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        // hold until the result register is free or being emptied
        if (!out_valid_q || !res_stall_i) begin
          wr_en               = 1'b1;
          total_d             = total_q + 1'b1;
          out_valid_d         = 1'b1;
          out_d.slot          = stt_pkg::SLOT_W'(sel_q);
          out_d.hit           = hit_q;
          out_d.evicted       = ev_q;
          out_d.data_out      = wr_data.data;
          out_d.battery_out   = wr_data.battery;
          out_d.elapsed_ms    = (base.last_report != '0) ?
                                req_q.now_ms - base.last_report : '0;
          out_d.report_count  = total_q + 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[sel_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      state_q     <= ST_IDLE;
      iss_q       <= '0;
      cmp_v_q     <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      hit_q       <= 1'b0;
      ev_q        <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[sel_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      state_q     <= state_d;
      iss_q       <= iss_d;
      cmp_v_q     <= cmp_v_d;
      found_q     <= found_d;
      free_q      <= free_d;
      hit_q       <= hit_d;
      ev_q        <= ev_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    match_q    <= match_d;
    free_idx_q <= free_idx_d;
    min_ls_q   <= min_ls_d;
    min_idx_q  <= min_idx_d;
    sel_q      <= sel_d;
    req_q      <= req_d;
    out_q      <= out_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/stt_checker.sv
// Port-level checks of the source tracking table, bound to the top level.
`default_nettype none

module stt_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_i,
  input wire logic                         out_stall_i,
  input wire logic [stt_pkg::SLOT_W-1:0]   slot_i,
  input wire logic                         hit_i,
  input wire logic                         evicted_i,
  input wire logic [stt_pkg::TIME_W-1:0]   elapsed_ms_i,
  input wire logic [stt_pkg::COUNT_W-1:0]  report_count_i
);

  logic                        seen_q;
  logic [stt_pkg::COUNT_W-1:0] last_cnt_q;
  logic                        xfer;

  assign xfer = out_valid_i && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_cnt_q <= '0;
    end else if (xfer) begin
      seen_q     <= 1'b1;
      last_cnt_q <= report_count_i;
    end
  end

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(slot_i) && $stable(report_count_i))
    else $error("result changed while stalled");

  a_hit_not_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(hit_i && evicted_i))
    else $error("hit and eviction flagged together");

  a_evict_no_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && evicted_i |-> elapsed_ms_i == '0)
    else $error("evicted entry reports a nonzero delta");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |-> report_count_i == (seen_q ? last_cnt_q + 1'b1 : stt_pkg::COUNT_W'(1)))
    else $error("report count does not advance by one per transfer");

endmodule

bind source_tracking_table stt_checker u_stt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .slot_i         (slot_o),
  .hit_i          (hit_o),
  .evicted_i      (evicted_o),
  .elapsed_ms_i   (elapsed_ms_o),
  .report_count_i (report_count_o)
);

`default_nettype wire

// File: verif/source_tracking_table_tb.sv
// Self-checking testbench for the source tracking table: directed, eviction and random reports.
module source_tracking_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int unsigned SLOTS = TABLE_SLOTS_DEF;
  localparam int unsigned MAX_SHOWN = 10;

  typedef enum int unsigned {STALL_NONE, STALL_CHOPPY, STALL_LONG} stall_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ADDR_W-1:0]   sender_addr_i = '0;
  logic [TIME_W-1:0]   now_ms_i = '0;
  logic                has_data_i = 1'b0;
  logic [BYTE_W-1:0]   data_value_i = '0;
  logic                has_battery_i = 1'b0;
  logic [BYTE_W-1:0]   battery_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [SLOT_W-1:0]   slot_o;
  logic                hit_o;
  logic                evicted_o;
  logic [BYTE_W-1:0]   data_out_o;
  logic [BYTE_W-1:0]   battery_out_o;
  logic [TIME_W-1:0]   elapsed_ms_o;
  logic [COUNT_W-1:0]  report_count_o;

  // Mirror of the tracking table
  bit [ADDR_W-1:0]  tracked_addr   [SLOTS];
  bit [TIME_W-1:0]  tracked_seen   [SLOTS];
  bit [TIME_W-1:0]  tracked_report [SLOTS];
  bit [BYTE_W-1:0]  tracked_data   [SLOTS];
  bit [BYTE_W-1:0]  tracked_battery[SLOTS];
  bit [COUNT_W-1:0] reports_done;

  result_t     updates_due[$];
  int unsigned fail_count;
  int unsigned results_checked;
  int unsigned burst_left;
  int unsigned mode_left;
  int unsigned run_left;
  stall_mode_e stall_mode = STALL_NONE;

  source_tracking_table #(.TableSlots(SLOTS)) DUT (.*);

  always #10 clk_i = ~clk_i;

  // Apply one report to the mirror and return the update the block should give
  function automatic result_t update_table(report_t item);
    result_t     res;
    int unsigned idx;
    int unsigned free_idx;
    bit          found;
    bit          have_free;
    bit          ev;
    idx = 0;
    free_idx = 0;
    found = 1'b0;
    have_free = 1'b0;
    ev = 1'b0;
    for (int i = 0; i < SLOTS && !found; i++) begin
      if (tracked_addr[i] == item.sender_addr) begin
        idx = i;
        found = 1'b1;
      end else if (tracked_addr[i] == '0 && !have_free) begin
        have_free = 1'b1;
        free_idx = i;
      end
    end
    if (!found) begin
      if (have_free) begin
        idx = free_idx;
      end else begin
        // evict the oldest, lowest index on ties, plain unsigned compare
        idx = 0;
        for (int i = 1; i < SLOTS; i++) begin
          if (tracked_seen[i] < tracked_seen[idx]) idx = i;
        end
        ev = 1'b1;
        tracked_report[idx] = '0;
        tracked_data[idx] = '0;
        tracked_battery[idx] = '0;
      end
      tracked_addr[idx] = item.sender_addr;
    end
    tracked_seen[idx] = item.now_ms;
    if (item.has_data) tracked_data[idx] = item.data_value;
    if (item.has_battery) tracked_battery[idx] = item.battery_value;
    res.elapsed_ms = (tracked_report[idx] != '0) ? item.now_ms - tracked_report[idx] : '0;
    tracked_report[idx] = item.now_ms;
    reports_done = reports_done + 1'b1;
    res.slot = SLOT_W'(idx);
    res.hit = found;
    res.evicted = ev;
    res.data_out = tracked_data[idx];
    res.battery_out = tracked_battery[idx];
    res.report_count = reports_done;
    return res;
  endfunction

  // Present one report in bursts with random gaps; returns at the falling edge after transfer
  task automatic send_report(input report_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 60);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    sender_addr_i   <= item.sender_addr;
    now_ms_i        <= item.now_ms;
    has_data_i      <= item.has_data;
    data_value_i    <= item.data_value;
    has_battery_i   <= item.has_battery;
    battery_value_i <= item.battery_value;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    updates_due.push_back(update_table(item));
    @(negedge clk_i);
  endtask

  task automatic send_fields(input bit [ADDR_W-1:0] addr, input bit [TIME_W-1:0] now,
                             input bit has_d, input bit [BYTE_W-1:0] dval,
                             input bit has_b, input bit [BYTE_W-1:0] bval);
    report_t item;
    item = '{sender_addr: addr, now_ms: now, has_data: has_d, data_value: dval,
             has_battery: has_b, battery_value: bval};
    send_report(item);
  endtask

  task automatic send_random_readings(input bit [ADDR_W-1:0] addr, input bit [TIME_W-1:0] now);
    send_fields(addr, now, $urandom_range(0, 3) != 0, BYTE_W'($urandom),
                $urandom_range(0, 3) != 0, BYTE_W'($urandom));
  endtask

  task automatic test_directed_reports();
    // first report at time zero, then its follow-up sees no previous report
    send_fields(16'hFFFF, 32'd0, 1'b1, 8'hFF, 1'b1, 8'hFF);
    send_fields(16'hFFFF, 32'd100, 1'b0, 8'h00, 1'b0, 8'h00);
    send_fields(16'hFFFF, 32'd350, 1'b1, 8'h00, 1'b1, 8'h00);
    // time wrap between two reports
    send_fields(16'h0001, 32'hFFFF_FFFF, 1'b1, 8'hAA, 1'b0, 8'hFF);
    send_fields(16'h0001, 32'd5, 1'b0, 8'hFF, 1'b1, 8'h5A);
    // zero address lands on the first free entry, which stays free
    send_fields(16'h0000, 32'd1000, 1'b1, 8'h55, 1'b1, 8'hA5);
    // claim of that entry keeps its stale readings and report time
    send_fields(16'h8000, 32'd1200, 1'b0, 8'h00, 1'b0, 8'h00);
    send_fields(16'h0000, 32'd0, 1'b0, 8'h00, 1'b1, 8'h01);
    send_fields(16'h1234, 32'h8000_0000, 1'b1, 8'h80, 1'b0, 8'h00);
    send_fields(16'h1234, 32'h7FFF_FFFF, 1'b0, 8'h00, 1'b0, 8'h00);
    send_fields(16'h5555, 32'h0000_1FFF, 1'b1, 8'h01, 1'b1, 8'hFE);
  endtask

  task automatic test_evict_oldest();
    localparam bit [TIME_W-1:0] FILL_MS = 32'h0000_2000;
    // send one report per entry, all at one time, so the next miss hits a tie
    for (int i = 0; i < SLOTS; i++) begin
      send_random_readings(ADDR_W'(16'h1000 + i), FILL_MS);
    end
    send_random_readings(16'h2000, FILL_MS + 1);
    send_fields(16'h2001, FILL_MS + 2, 1'b0, 8'h00, 1'b0, 8'h00);
    // last-seen times straddling the wrap point
    send_random_readings(16'h2002, 32'hFFFF_FFF0);
    send_random_readings(16'h2003, 32'hFFFF_FFFA);
    send_random_readings(16'h2004, 32'd3);
    send_random_readings(16'h2005, 32'd8);
    send_random_readings(16'h2002, 32'd9);
    // zero address on a full table evicts and leaves the entry free
    send_random_readings(16'h0000, 32'd10);
    send_fields(16'h3000, 32'd11, 1'b0, 8'h00, 1'b0, 8'h00);
    send_fields(16'h1005, 32'd12, 1'b0, 8'h00, 1'b0, 8'h00);
    send_random_readings(16'h1010, 32'd13);
    send_random_readings(16'h3001, 32'd14);
  endtask

  task automatic test_random_reports(input int unsigned count);
    bit [ADDR_W-1:0] pool[48];
    int unsigned     pool_size;
    int unsigned     pick;
    bit [TIME_W-1:0] now;
    bit [ADDR_W-1:0] addr;
    for (int i = 0; i < 48; i++) pool[i] = ADDR_W'($urandom_range(1, 65535));
    pool_size = 40;
    now = $urandom;
    for (int n = 0; n < count; n++) begin
      // vary the pool so hit and eviction rates shift through the run
      if (n % 100 == 0) pool_size = $urandom_range(8, 48);
      if ($urandom_range(0, 9) == 0) pool[$urandom_range(0, 47)] = ADDR_W'($urandom_range(1, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 85) addr = pool[$urandom_range(0, pool_size - 1)];
      else if (pick < 97) addr = ADDR_W'($urandom_range(1, 65535));
      else addr = '0;
      pick = $urandom_range(0, 99);
      if (pick < 90) now = now + $urandom_range(0, 2000);
      else if (pick < 95) now = $urandom;
      else if (pick < 97) now = '0;
      else now = 32'hFFFF_FF00 + $urandom_range(0, 255);
      send_random_readings(addr, now);
    end
  endtask

  // Receiver stall pattern: quiet, choppy or long holds, switched now and then
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 300);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_CHOPPY: out_stall_i <= 1'($urandom_range(0, 1));
      default: begin
        if (run_left == 0) begin
          out_stall_i <= ~out_stall_i;
          run_left = $urandom_range(1, 30);
        end
        run_left--;
      end
    endcase
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    result_t got;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      got = '{slot: slot_o, hit: hit_o, evicted: evicted_o, data_out: data_out_o,
              battery_out: battery_out_o, elapsed_ms: elapsed_ms_o,
              report_count: report_count_o};
      if (updates_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("%0t: result with none outstanding: slot %0d count %0d",
                   $realtime, got.slot, got.report_count);
      end else begin
        want = updates_due.pop_front();
        if (got.slot !== want.slot || got.hit !== want.hit || got.evicted !== want.evicted ||
            got.data_out !== want.data_out || got.battery_out !== want.battery_out ||
            got.elapsed_ms !== want.elapsed_ms ||
            got.report_count !== want.report_count) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display({"%0t: result %0d (expected/actual) slot %0d/%0d hit %0b/%0b ",
                      "evicted %0b/%0b data %02h/%02h battery %02h/%02h ",
                      "delta %0d/%0d count %0d/%0d"},
                     $realtime, results_checked, want.slot, got.slot, want.hit, got.hit,
                     want.evicted, got.evicted, want.data_out, got.data_out,
                     want.battery_out, got.battery_out, want.elapsed_ms, got.elapsed_ms,
                     want.report_count, got.report_count);
        end
      end
      results_checked++;
    end
  end

  initial begin
    int unsigned wait_cycles;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_reports();
    test_evict_oldest();
    test_random_reports(500);
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (updates_due.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (40) @(posedge clk_i);
    if (updates_due.size() != 0) begin
      fail_count += updates_due.size();
      $display("%0d results never arrived", updates_due.size());
    end
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/stt_pkg.sv
hw/rtl/stt_queue.sv
hw/rtl/stt_engine.sv
hw/rtl/source_tracking_table.sv
hw/rtl/stt_checker.sv
verif/source_tracking_table_tb.sv
